/* hdl/box_downsample_pow2_top_defines.svh */
// ----------------------------------------------------------------------------
// box_downsample_pow2_top_defines.svh
// Assertion macros shared by the downsampler checker.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_POW2_TOP_DEFINES_SVH
`define BOX_DOWNSAMPLE_POW2_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BDP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define BDP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bdp_pkg.sv */
// ----------------------------------------------------------------------------
// bdp_pkg
// Types and constants of the power-of-two box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bdp_pkg;

   // default sizes of the design
   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_LEVEL_DEF   = 7;

   // fixed port and register widths
   localparam int PORT_BITS   = 16;
   localparam int COORD_BITS  = 12;
   localparam int DIM_BITS    = 13;
   localparam int LEVEL_BITS  = 3;
   localparam int ROW_BITS    = 12;
   localparam int ROW_LIMIT   = 4096;
   localparam int CSR_IDX_BITS = 2;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register reset values
   localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 13'd4096;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 13'd4096;
   localparam logic [LEVEL_BITS-1:0] LEVEL_RST  = 3'd1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SCALE_LEVEL  = 2'd2
   } csr_index_type;

   // configuration as held in registers
   typedef struct packed {
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      logic [LEVEL_BITS-1:0] level;
   } cfg_type;

   // per-item control flags from front to back
   typedef struct packed {
      logic first;       // top-left pixel of its block
      logic last;        // bottom-right pixel of its block
      logic frame_last;  // block is the final one of the image
   } flags_type;

endpackage

`default_nettype wire

/* hdl/box_downsample_pow2_top.sv */
// A result appears on rsp_valid once the block's last pixel has passed the queue
// slot, then the line-store read and accumulate. Throughput: 1 pixel per cycle
// unless a held result is stalled, set by one read and one write of the line
// store each cycle with one-step write forwarding. A 4-item queue decouples input.
// Reset (synchronous): counters, queue and result valid clear; registers
// return to width 4096, height 4096, level 1. Sum store contents stay as is.
// ----------------------------------------------------------------------------
// box_downsample_pow2_top
// Averages each 2^level square block of an RGB raster stream.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_pow2_top #(
   parameter int MAX_WIDTH   = bdp_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = bdp_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_LEVEL   = bdp_pkg::MAX_LEVEL_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [bdp_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [bdp_pkg::DIM_BITS-1:0]          csr_data,
   // pixel input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [bdp_pkg::PORT_BITS-1:0]         req_red_in,
   input  wire logic [bdp_pkg::PORT_BITS-1:0]         req_green_in,
   input  wire logic [bdp_pkg::PORT_BITS-1:0]         req_blue_in,
   // result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [bdp_pkg::PORT_BITS-1:0]         rsp_red_out,
   output logic      [bdp_pkg::PORT_BITS-1:0]         rsp_green_out,
   output logic      [bdp_pkg::PORT_BITS-1:0]         rsp_blue_out,
   output logic      [bdp_pkg::COORD_BITS-1:0]        rsp_out_col,
   output logic      [bdp_pkg::COORD_BITS-1:0]        rsp_out_row,
   output logic                                       rsp_frame_last
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int LVL_BITS  = $clog2(MAX_LEVEL + 1);
   localparam int ROW_BITS  = bdp_pkg::ROW_BITS;
   localparam int FLAG_BITS = $bits(bdp_pkg::flags_type);
   localparam int ENTRY_BITS = FLAG_BITS + COL_BITS + ROW_BITS + 3 * SAMPLE_BITS;

   bdp_pkg::cfg_type     cfg_ff, cfg_in;
   logic [LVL_BITS-1:0]  lv;
   logic                 take;
   logic                 push, q_full, q_valid, pop;
   bdp_pkg::flags_type   f_flags, q_flags;
   logic [COL_BITS-1:0]  f_bx, q_bx;
   logic [ROW_BITS-1:0]  f_by, q_by;
   logic [SAMPLE_BITS-1:0] q_red, q_green, q_blue;
   logic [ENTRY_BITS-1:0] push_data, head;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (bdp_pkg::csr_index_type'(csr_index))
            bdp_pkg::CSR_IMAGE_WIDTH:  cfg_in.width  = csr_data;
            bdp_pkg::CSR_IMAGE_HEIGHT: cfg_in.height = csr_data;
            bdp_pkg::CSR_SCALE_LEVEL:  cfg_in.level  = csr_data[bdp_pkg::LEVEL_BITS-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= bdp_pkg::WIDTH_RST;
         cfg_ff.height <= bdp_pkg::HEIGHT_RST;
         cfg_ff.level  <= bdp_pkg::LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // level clamped to the supported range
   assign lv = (32'(cfg_ff.level) > MAX_LEVEL) ? LVL_BITS'(MAX_LEVEL)
                                               : LVL_BITS'(cfg_ff.level);

   // input handshake
   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   bdp_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_LEVEL (MAX_LEVEL)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .lv    (lv),
      .take  (take),
      .push  (push),
      .flags (f_flags),
      .bx    (f_bx),
      .by    (f_by)
   );

   assign push_data = {f_flags, f_bx, f_by,
                       SAMPLE_BITS'(req_red_in),
                       SAMPLE_BITS'(req_green_in),
                       SAMPLE_BITS'(req_blue_in)};

   bdp_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (bdp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (head)
   );

   assign {q_flags, q_bx, q_by, q_red, q_green, q_blue} = head;

   bdp_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_LEVEL   (MAX_LEVEL)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .lv             (lv),
      .q_valid        (q_valid),
      .q_flags        (q_flags),
      .q_bx           (q_bx),
      .q_by           (q_by),
      .q_red          (q_red),
      .q_green        (q_green),
      .q_blue         (q_blue),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

/* hdl/bdp_ram.sv */
// ----------------------------------------------------------------------------
// bdp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/bdp_queue.sv */
// ----------------------------------------------------------------------------
// bdp_queue
// Short register FIFO between the classifying front and the summing back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bdp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic      [WIDTH-1:0] head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/bdp_front.sv */
// ----------------------------------------------------------------------------
// bdp_front
// Raster position counters and block classification of each pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_front #(
   parameter int MAX_WIDTH = bdp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_LEVEL = bdp_pkg::MAX_LEVEL_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bdp_pkg::cfg_type                      cfg,
   input  wire logic [$clog2(MAX_LEVEL+1)-1:0]        lv,
   input  wire logic                                  take,
   output logic                                       push,
   output bdp_pkg::flags_type                         flags,
   output logic      [$clog2(MAX_WIDTH)-1:0]          bx,
   output logic      [bdp_pkg::ROW_BITS-1:0]          by
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int EW_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS = bdp_pkg::ROW_BITS;
   localparam int DIM_BITS = bdp_pkg::DIM_BITS;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [EW_BITS-1:0]  eff_w, rw;
   logic [DIM_BITS-1:0] eff_h, rh;
   logic [COL_BITS-1:0] col_mask;
   logic [ROW_BITS-1:0] row_mask;
   logic                in_block;

   // clamp the frame size
   always_comb begin
      if (cfg.width == '0) begin
         eff_w = EW_BITS'(1);
      end else if (32'(cfg.width) > MAX_WIDTH) begin
         eff_w = EW_BITS'(MAX_WIDTH);
      end else begin
         eff_w = EW_BITS'(cfg.width);
      end
      if (cfg.height == '0) begin
         eff_h = DIM_BITS'(1);
      end else if (32'(cfg.height) > bdp_pkg::ROW_LIMIT) begin
         eff_h = DIM_BITS'(bdp_pkg::ROW_LIMIT);
      end else begin
         eff_h = cfg.height;
      end
   end

   // block coordinates and offsets within the block
   assign col_mask = COL_BITS'((32'd1 << lv) - 32'd1);
   assign row_mask = ROW_BITS'((32'd1 << lv) - 32'd1);
   assign bx       = col_ff >> lv;
   assign by       = row_ff >> lv;
   assign rw       = eff_w >> lv;
   assign rh       = eff_h >> lv;
   assign in_block = (32'(bx) < 32'(rw)) && (32'(by) < 32'(rh));

   assign flags.first      = ((col_ff & col_mask) == '0) && ((row_ff & row_mask) == '0);
   assign flags.last       = ((col_ff & col_mask) == col_mask)
                          && ((row_ff & row_mask) == row_mask);
   assign flags.frame_last = (32'(bx) + 32'd1 == 32'(rw)) && (32'(by) + 32'd1 == 32'(rh));

   // pixels outside whole blocks only move the counters
   assign push = take && in_block;

   // raster position advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (32'(col_ff) + 32'd1 >= 32'(eff_w)) begin
            col_in = '0;
            row_in = (32'(row_ff) + 32'd1 >= 32'(eff_h)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/bdp_back.sv */
// ----------------------------------------------------------------------------
// bdp_back
// Line-store read-modify-write of the block sums and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_back #(
   parameter int MAX_WIDTH   = bdp_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = bdp_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_LEVEL   = bdp_pkg::MAX_LEVEL_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [$clog2(MAX_LEVEL+1)-1:0]        lv,
   // queue head
   input  wire logic                                  q_valid,
   input  wire bdp_pkg::flags_type                    q_flags,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]          q_bx,
   input  wire logic [bdp_pkg::ROW_BITS-1:0]          q_by,
   input  wire logic [SAMPLE_BITS-1:0]                q_red,
   input  wire logic [SAMPLE_BITS-1:0]                q_green,
   input  wire logic [SAMPLE_BITS-1:0]                q_blue,
   output logic                                       pop,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [bdp_pkg::PORT_BITS-1:0]         rsp_red_out,
   output logic      [bdp_pkg::PORT_BITS-1:0]         rsp_green_out,
   output logic      [bdp_pkg::PORT_BITS-1:0]         rsp_blue_out,
   output logic      [bdp_pkg::COORD_BITS-1:0]        rsp_out_col,
   output logic      [bdp_pkg::COORD_BITS-1:0]        rsp_out_row,
   output logic                                       rsp_frame_last
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int LVL_BITS  = $clog2(MAX_LEVEL + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + 2 * MAX_LEVEL;
   localparam int RAM_BITS  = 3 * SUM_BITS;
   localparam int ROW_BITS  = bdp_pkg::ROW_BITS;
   localparam int PORT_BITS = bdp_pkg::PORT_BITS;
   localparam int COORD_BITS = bdp_pkg::COORD_BITS;

   logic                   adv;
   logic                   wr_en;
   logic [RAM_BITS-1:0]    rd_data;
   logic [RAM_BITS-1:0]    wr_data;

   // stage B: item whose line-store read is in flight
   logic                   b_valid_ff, b_valid_in;
   bdp_pkg::flags_type     b_flags_ff;
   logic [COL_BITS-1:0]    b_bx_ff;
   logic [ROW_BITS-1:0]    b_by_ff;
   logic [SAMPLE_BITS-1:0] b_red_ff, b_green_ff, b_blue_ff;

   // last write, forwarded to a read that raced it
   logic                   fwd_valid_ff;
   logic [COL_BITS-1:0]    fwd_addr_ff;
   logic [RAM_BITS-1:0]    fwd_data_ff;

   logic [RAM_BITS-1:0]    old_sums;
   logic [SUM_BITS-1:0]    old_red, old_green, old_blue;
   logic [SUM_BITS-1:0]    new_red, new_green, new_blue;
   logic [SUM_BITS-1:0]    avg_red, avg_green, avg_blue;
   logic [LVL_BITS:0]      sh;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [PORT_BITS-1:0]   out_red_ff, out_green_ff, out_blue_ff;
   logic [COORD_BITS-1:0]  out_col_ff, out_row_ff;
   logic                   out_last_ff;

   // the back half moves unless a held result blocks it
   assign adv   = !(out_valid_ff && rsp_stall);
   assign pop   = adv && q_valid;
   assign wr_en = adv && b_valid_ff;

   bdp_ram #(
      .WIDTH (RAM_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_bx_ff),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (q_bx),
      .rd_data (rd_data)
   );

   // accumulate; the top-left pixel restarts the sums
   always_comb begin
      old_sums = (fwd_valid_ff && (fwd_addr_ff == b_bx_ff)) ? fwd_data_ff : rd_data;
      old_red   = old_sums[3*SUM_BITS-1:2*SUM_BITS];
      old_green = old_sums[2*SUM_BITS-1:SUM_BITS];
      old_blue  = old_sums[SUM_BITS-1:0];
      if (b_flags_ff.first) begin
         new_red   = SUM_BITS'(b_red_ff);
         new_green = SUM_BITS'(b_green_ff);
         new_blue  = SUM_BITS'(b_blue_ff);
      end else begin
         new_red   = old_red + SUM_BITS'(b_red_ff);
         new_green = old_green + SUM_BITS'(b_green_ff);
         new_blue  = old_blue + SUM_BITS'(b_blue_ff);
      end
      wr_data = {new_red, new_green, new_blue};
   end

   // mean by shift of twice the level
   assign sh        = {lv, 1'b0};
   assign avg_red   = new_red >> sh;
   assign avg_green = new_green >> sh;
   assign avg_blue  = new_blue >> sh;

   assign b_valid_in   = adv ? pop : b_valid_ff;
   assign out_valid_in = adv ? (b_valid_ff && b_flags_ff.last) : out_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         b_flags_ff <= q_flags;
         b_bx_ff    <= q_bx;
         b_by_ff    <= q_by;
         b_red_ff   <= q_red;
         b_green_ff <= q_green;
         b_blue_ff  <= q_blue;
      end
      if (wr_en) begin
         fwd_addr_ff <= b_bx_ff;
         fwd_data_ff <= wr_data;
      end
      if (wr_en && b_flags_ff.last) begin
         out_red_ff   <= PORT_BITS'(SAMPLE_BITS'(avg_red));
         out_green_ff <= PORT_BITS'(SAMPLE_BITS'(avg_green));
         out_blue_ff  <= PORT_BITS'(SAMPLE_BITS'(avg_blue));
         out_col_ff   <= COORD_BITS'(b_bx_ff);
         out_row_ff   <= COORD_BITS'(b_by_ff);
         out_last_ff  <= b_flags_ff.frame_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red_out    = out_red_ff;
   assign rsp_green_out  = out_green_ff;
   assign rsp_blue_out   = out_blue_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

`default_nettype wire

/* hdl/bdp_chk.sv */
// ----------------------------------------------------------------------------
// bdp_chk
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_downsample_pow2_top_defines.svh"

module bdp_chk (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             csr_valid,
   input wire logic                             csr_ready,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [bdp_pkg::PORT_BITS-1:0]    rsp_red_out,
   input wire logic [bdp_pkg::PORT_BITS-1:0]    rsp_green_out,
   input wire logic [bdp_pkg::PORT_BITS-1:0]    rsp_blue_out,
   input wire logic [bdp_pkg::COORD_BITS-1:0]   rsp_out_col,
   input wire logic [bdp_pkg::COORD_BITS-1:0]   rsp_out_row,
   input wire logic                             rsp_frame_last
);

   localparam int RSP_BITS = 3 * bdp_pkg::PORT_BITS + 2 * bdp_pkg::COORD_BITS + 1;

   logic [RSP_BITS-1:0] rsp_payload;

   // whole result item as one vector
   assign rsp_payload = {rsp_red_out, rsp_green_out, rsp_blue_out,
                         rsp_out_col, rsp_out_row, rsp_frame_last};

   // a result never appears out of reset
   `BDP_ASSERT_NEXT_ALWAYS(a_rsp_clear, clock, reset, !rsp_valid, "result valid after reset")

   // input side is open right after reset
   `BDP_ASSERT_NEXT_ALWAYS(a_req_open, clock, reset, !req_stall, "input stalled after reset")

   // configuration writes are never refused
   `BDP_ASSERT_IMPL(a_csr_ready, clock, reset, csr_valid, csr_ready, "config write refused")

   // a stalled input item stays offered
   `BDP_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid, "input item dropped")

   // a stalled result holds
   `BDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind box_downsample_pow2_top bdp_chk u_bdp_chk (
   .clock          (clock),
   .reset          (reset),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_red_out    (rsp_red_out),
   .rsp_green_out  (rsp_green_out),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_out_col    (rsp_out_col),
   .rsp_out_row    (rsp_out_row),
   .rsp_frame_last (rsp_frame_last)
);

`default_nettype wire
